>>> sv/rcpi_pkg.sv
// Shared types, constants and saturating helpers for the ray / convex polyhedron unit.
// No dependencies; the top level and the testbench refer to it by scoped names.
package rcpi_pkg;

   // Plane table geometry
   localparam int MAX_FACES = 32;
   localparam int FACE_W    = $clog2(MAX_FACES);
   localparam int CNT_W     = $clog2(MAX_FACES + 1);
   localparam int PLANE_W   = 128;

   // Register reset values
   localparam logic [31:0] PAR_THR_RESET = 32'd4295;

   // Register indexes (byte address bit 2 selects)
   localparam logic REG_MIN_DIST = 1'b0;
   localparam logic REG_PAR_THR  = 1'b1;

   // Fixed-point extremes
   localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [63:0] I64_MIN = {1'b1, 63'd0};
   localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [17:0] UNIT_ONE = 18'sd65536;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TRACE  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_FINAL,
      ST_NSQ,
      ST_SQRT,
      ST_SQRT_WAIT,
      ST_NDIV,
      ST_NDIV_WAIT,
      ST_POINT,
      ST_DONE
   } state_type;

   // Signed 64-bit add that clamps to the 64-bit range
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) begin
         sat_add64 = sum[64] ? I64_MIN : I64_MAX;
      end else begin
         sat_add64 = sum[63:0];
      end
   endfunction

   // Clamp a signed 64-bit value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         sat32 = I32_MAX;
      end else if (x < -64'sd2147483648) begin
         sat32 = I32_MIN;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   // Magnitude of a signed 64-bit value as unsigned
   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      mag64 = x[63] ? 64'(~x + 64'd1) : x;
   endfunction

   // Magnitude of a signed 32-bit value as unsigned
   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      mag32 = x[31] ? 32'(~x + 32'd1) : x;
   endfunction

endpackage

>>> sv/rcpi_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing but the field widths listed here.
interface rcpi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] coef_a;
   logic signed [31:0] coef_b;
   logic signed [31:0] coef_c;
   logic signed [31:0] coef_d;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic signed [31:0] max_distance;

   modport source (output valid, opcode, coef_a, coef_b, coef_c, coef_d, origin_x, origin_y,
                   origin_z, dir_x, dir_y, dir_z, max_distance, input ready);
   modport sink (input valid, opcode, coef_a, coef_b, coef_c, coef_d, origin_x, origin_y,
                 origin_z, dir_x, dir_y, dir_z, max_distance, output ready);
endinterface

interface rcpi_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] hit_distance;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [17:0] normal_x;
   logic signed [17:0] normal_y;
   logic signed [17:0] normal_z;
   logic [4:0]         hit_face;
   logic               no_entry_face;

   modport source (output valid, hit, hit_distance, point_x, point_y, point_z, normal_x,
                   normal_y, normal_z, hit_face, no_entry_face, input ready);
   modport sink (input valid, hit, hit_distance, point_x, point_y, point_z, normal_x,
                 normal_y, normal_z, hit_face, no_entry_face, output ready);
endinterface

>>> sv/rcpi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
module rcpi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rcpi_div.sv
// Restoring divider, one quotient bit a cycle: quo = floor(num * 2^16 / den).
// Caller guarantees num < den * 2^17, so the quotient fits in 33 bits.
module rcpi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [32:0] quo
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [32:0] sh_ff, sh_in;
   logic [32:0] quo_ff, quo_in;
   logic [64:0] trial;

   // One trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, sh_ff[32]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd33;
         rem_in  = num >> 17;
         den_in  = den;
         sh_in   = {num[16:0], 16'd0};
         quo_in  = '0;
      end else if (busy_ff) begin
         sh_in = {sh_ff[31:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> sv/rcpi_sqrt.sv
// Bit-pair integer square root, one result bit a cycle: root = floor(sqrt(val)).
// Standalone; used for the face normal length.
module rcpi_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] val,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  k_ff, k_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_w;
   logic [63:0] tst_w;

   // Test one bit pair per cycle, from bit 62 down
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_w   = 64'd1 << {k_ff, 1'b0};
      tst_w   = res_ff + bit_w;
      if (start) begin
         busy_in = 1'b1;
         k_in    = 5'd31;
         v_in    = val;
         res_in  = '0;
      end else if (busy_ff) begin
         if (v_ff >= tst_w) begin
            v_in   = v_ff - tst_w;
            res_in = (res_ff >> 1) + bit_w;
         end else begin
            res_in = res_ff >> 1;
         end
         k_in = k_ff - 5'd1;
         if (k_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

>>> sv/ray_convex_polyhedron_intersect_unit.sv
// Ray against convex polyhedron: plane table in RAM, sequencer, shared multiplier.
// Depends on rcpi_pkg, rcpi_if, rcpi_ram, rcpi_div and rcpi_sqrt.
//
//  channel | dir | handshake          | carries
//  req_ch  | in  | valid / ready      | opcode, plane coefficients, ray, max_distance
//  rsp_ch  | out | valid / ready      | hit, distance, point, unit normal, face
//  csr     | in  | APB psel / penable | min_distance (0x0), parallel_threshold (0x4)
//
// Clear, append and unused opcodes leave the sequencer idle and give no response.
// A trace steps through each stored face: RAM read, 6 products, then the divider unless
// the face is parallel or its distance overflows; a hit on an entering face then takes
// a square root and three normal divides.
// Reset is synchronous; the table needs no clearing pass, only the face count resets.
// A finished response waits in the output register while the next item is taken;
// a trace that finishes before that response is taken holds until it is.
module ray_convex_polyhedron_intersect_unit (
   input  logic              clock,
   input  logic              reset,
   rcpi_req_if.sink          req_ch,
   rcpi_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Control state
   rcpi_pkg::state_type                state_ff, state_in;
   logic [rcpi_pkg::CNT_W-1:0]         face_count_ff, face_count_in;
   logic [rcpi_pkg::CNT_W-1:0]         idx_ff, idx_in;
   logic [2:0]                         step_ff, step_in;
   logic [1:0]                         comp_ff, comp_in;
   logic                               face_ok_ff, face_ok_in;
   logic                               miss_ff, miss_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [30:0]                        min_dist_ff, min_dist_in;
   logic [31:0]                        thr_ff, thr_in;

   // Datapath
   logic signed [31:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff, tmax_ff;
   logic signed [31:0] ox_in, oy_in, oz_in, dx_in, dy_in, dz_in, tmax_in;
   logic signed [63:0] vn_ff, vn_in, s_ff, s_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [31:0] t_ff, t_in, t_near_ff, t_near_in, t_far_ff, t_far_in;
   logic signed [31:0] t_hit_ff, t_hit_in;
   logic [rcpi_pkg::FACE_W-1:0] face_ff, face_in;
   logic signed [31:0] ba_ff, bb_ff, bc_ff, ba_in, bb_in, bc_in;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        len_ff, len_in;
   logic signed [17:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic signed [31:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;

   // Output register
   logic               o_hit_ff, o_hit_in, o_nef_ff, o_nef_in;
   logic signed [31:0] o_dist_ff, o_dist_in, o_px_ff, o_px_in, o_py_ff, o_py_in;
   logic signed [31:0] o_pz_ff, o_pz_in;
   logic signed [17:0] o_nx_ff, o_nx_in, o_ny_ff, o_ny_in, o_nz_ff, o_nz_in;
   logic [4:0]         o_face_ff, o_face_in;

   // Combinational helpers
   logic                                   accept_w, cfg_wr_w;
   logic                                   ram_we, ram_re;
   logic [rcpi_pkg::PLANE_W-1:0]           ram_wdata, ram_rdata;
   logic signed [31:0]                     ra_w, rb_w, rc_w, rd_w;
   logic signed [32:0]                     mul_a_w, mul_b_w;
   logic signed [63:0]                     vd_w, pt_w, mp_w;
   logic [63:0]                            vn_mag_w, vd_mag_w;
   logic                                   par_w, ovf_w, neg_w;
   logic                                   div_start, div_done, sqrt_start, sqrt_done;
   logic [63:0]                            div_num, div_den;
   logic [32:0]                            div_quo;
   logic [31:0]                            sqrt_root;
   logic signed [31:0]                     min_s_w, th_w, cmag_sel_w;
   logic [16:0]                            q17_w;
   logic signed [17:0]                     nval_w;

   // Turn the divider magnitude into the signed, saturated Q16.16 distance
   function automatic logic signed [31:0] fix_t(input logic neg, input logic big,
                                                input logic [32:0] m);
      if (big) begin
         fix_t = neg ? rcpi_pkg::I32_MIN : rcpi_pkg::I32_MAX;
      end else if (neg) begin
         fix_t = (m >= 33'h0_8000_0000) ? rcpi_pkg::I32_MIN : 32'sd0 - $signed(m[31:0]);
      end else begin
         fix_t = (m > 33'h0_7FFF_FFFF) ? rcpi_pkg::I32_MAX : $signed(m[31:0]);
      end
   endfunction

   assign accept_w = req_ch.valid && req_ch.ready;
   assign cfg_wr_w = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == rcpi_pkg::REG_PAR_THR) ? thr_ff : {1'b0, min_dist_ff};

   // Plane table
   assign ram_we    = accept_w && (req_ch.opcode == rcpi_pkg::OP_APPEND) &&
                      (face_count_ff < rcpi_pkg::CNT_W'(rcpi_pkg::MAX_FACES));
   assign ram_wdata = {req_ch.coef_a, req_ch.coef_b, req_ch.coef_c, req_ch.coef_d};
   assign ram_re    = (state_ff == rcpi_pkg::ST_READ);

   rcpi_ram #(
      .WIDTH (rcpi_pkg::PLANE_W),
      .DEPTH (rcpi_pkg::MAX_FACES)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (face_count_ff[rcpi_pkg::FACE_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[rcpi_pkg::FACE_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign ra_w = ram_rdata[127:96];
   assign rb_w = ram_rdata[95:64];
   assign rc_w = ram_rdata[63:32];
   assign rd_w = ram_rdata[31:0];

   // Plane test terms
   assign vd_w     = (s_ff == rcpi_pkg::I64_MIN) ? rcpi_pkg::I64_MAX : -s_ff;
   assign vn_mag_w = rcpi_pkg::mag64(vn_ff);
   assign vd_mag_w = rcpi_pkg::mag64(vd_w);
   assign par_w    = (vn_ff == 64'sd0) || (vn_mag_w < {32'd0, thr_ff});
   assign ovf_w    = (vd_mag_w >> 17) >= vn_mag_w;
   assign neg_w    = vd_w[63] ^ vn_ff[63];

   // Normal component under division
   always_comb begin
      unique case (comp_ff)
         2'd0:    cmag_sel_w = ba_ff;
         2'd1:    cmag_sel_w = bb_ff;
         default: cmag_sel_w = bc_ff;
      endcase
   end

   assign div_num = (state_ff == rcpi_pkg::ST_CHECK) ? vd_mag_w
                                                    : {32'd0, rcpi_pkg::mag32(cmag_sel_w)};
   assign div_den = (state_ff == rcpi_pkg::ST_CHECK) ? vn_mag_w : {32'd0, len_ff};

   rcpi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   rcpi_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .val   (sq_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign q17_w  = (div_quo > 33'd65536) ? 17'd65536 : div_quo[16:0];
   assign nval_w = cmag_sel_w[31] ? 18'sd0 - $signed({1'b0, q17_w}) : $signed({1'b0, q17_w});
   assign min_s_w = $signed({1'b0, min_dist_ff});
   assign th_w    = (t_near_ff < min_s_w) ? t_far_ff : t_near_ff;
   assign mp_w    = prod_ff[63:0];
   assign pt_w    = mp_w >>> 16;

   // Shared multiplier operand select
   always_comb begin
      mul_a_w = '0;
      mul_b_w = '0;
      if (state_ff == rcpi_pkg::ST_MUL) begin
         unique case (step_ff)
            3'd0:    begin mul_a_w = {ra_w[31], ra_w}; mul_b_w = {dx_ff[31], dx_ff}; end
            3'd1:    begin mul_a_w = {rb_w[31], rb_w}; mul_b_w = {dy_ff[31], dy_ff}; end
            3'd2:    begin mul_a_w = {rc_w[31], rc_w}; mul_b_w = {dz_ff[31], dz_ff}; end
            3'd3:    begin mul_a_w = {ra_w[31], ra_w}; mul_b_w = {ox_ff[31], ox_ff}; end
            3'd4:    begin mul_a_w = {rb_w[31], rb_w}; mul_b_w = {oy_ff[31], oy_ff}; end
            3'd5:    begin mul_a_w = {rc_w[31], rc_w}; mul_b_w = {oz_ff[31], oz_ff}; end
            default: begin mul_a_w = '0; mul_b_w = '0; end
         endcase
      end else if (state_ff == rcpi_pkg::ST_NSQ) begin
         unique case (step_ff)
            3'd0: begin
               mul_a_w = $signed({1'b0, rcpi_pkg::mag32(ba_ff)});
               mul_b_w = mul_a_w;
            end
            3'd1: begin
               mul_a_w = $signed({1'b0, rcpi_pkg::mag32(bb_ff)});
               mul_b_w = mul_a_w;
            end
            3'd2: begin
               mul_a_w = $signed({1'b0, rcpi_pkg::mag32(bc_ff)});
               mul_b_w = mul_a_w;
            end
            default: begin mul_a_w = '0; mul_b_w = '0; end
         endcase
      end else if (state_ff == rcpi_pkg::ST_POINT) begin
         mul_a_w = {t_hit_ff[31], t_hit_ff};
         unique case (step_ff)
            3'd0:    mul_b_w = {dx_ff[31], dx_ff};
            3'd1:    mul_b_w = {dy_ff[31], dy_ff};
            3'd2:    mul_b_w = {dz_ff[31], dz_ff};
            default: mul_b_w = '0;
         endcase
      end
      prod_in = mul_a_w * mul_b_w;
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      face_count_in = face_count_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      comp_in       = comp_ff;
      face_ok_in    = face_ok_ff;
      miss_in       = miss_ff;
      min_dist_in   = min_dist_ff;
      thr_in        = thr_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      tmax_in   = tmax_ff;
      vn_in     = vn_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      t_near_in = t_near_ff;
      t_far_in  = t_far_ff;
      t_hit_in  = t_hit_ff;
      face_in   = face_ff;
      ba_in = ba_ff; bb_in = bb_ff; bc_in = bc_ff;
      sq_in  = sq_ff;
      len_in = len_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_hit_in  = o_hit_ff;  o_nef_in = o_nef_ff;
      o_dist_in = o_dist_ff; o_px_in  = o_px_ff; o_py_in = o_py_ff; o_pz_in = o_pz_ff;
      o_nx_in   = o_nx_ff;   o_ny_in  = o_ny_ff; o_nz_in = o_nz_ff;
      o_face_in = o_face_ff;

      // Register writes
      if (cfg_wr_w) begin
         unique case (paddr[2])
            rcpi_pkg::REG_MIN_DIST: min_dist_in = pwdata[30:0];
            default:                thr_in      = pwdata;
         endcase
      end

      unique case (state_ff)
         rcpi_pkg::ST_IDLE: begin
            if (accept_w) begin
               unique case (rcpi_pkg::opcode_type'(req_ch.opcode))
                  rcpi_pkg::OP_CLEAR: face_count_in = '0;
                  rcpi_pkg::OP_APPEND: begin
                     if (ram_we) begin
                        face_count_in = face_count_ff + rcpi_pkg::CNT_W'(1);
                     end
                  end
                  rcpi_pkg::OP_TRACE: begin
                     ox_in = req_ch.origin_x; oy_in = req_ch.origin_y;
                     oz_in = req_ch.origin_z;
                     dx_in = req_ch.dir_x; dy_in = req_ch.dir_y; dz_in = req_ch.dir_z;
                     tmax_in    = req_ch.max_distance;
                     t_near_in  = rcpi_pkg::I32_MIN;
                     t_far_in   = rcpi_pkg::I32_MAX;
                     face_in    = '0;
                     face_ok_in = 1'b0;
                     miss_in    = 1'b0;
                     idx_in     = '0;
                     state_in   = (face_count_ff == '0) ? rcpi_pkg::ST_FINAL
                                                        : rcpi_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end

         rcpi_pkg::ST_READ: begin
            vn_in    = '0;
            s_in     = '0;
            step_in  = '0;
            state_in = rcpi_pkg::ST_MUL;
         end

         // Accumulate the products from the product register, then add the plane offset
         rcpi_pkg::ST_MUL: begin
            if (step_ff >= 3'd1 && step_ff <= 3'd3) begin
               vn_in = rcpi_pkg::sat_add64(vn_ff, mp_w);
            end else if (step_ff >= 3'd4 && step_ff <= 3'd6) begin
               s_in = rcpi_pkg::sat_add64(s_ff, mp_w);
            end else if (step_ff == 3'd7) begin
               s_in = rcpi_pkg::sat_add64(s_ff, {{16{rd_w[31]}}, rd_w, 16'd0});
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = rcpi_pkg::ST_CHECK;
            end
         end

         rcpi_pkg::ST_CHECK: begin
            if (par_w) begin
               if (vd_w[63]) begin
                  miss_in  = 1'b1;
                  state_in = rcpi_pkg::ST_DONE;
               end else begin
                  idx_in   = idx_ff + rcpi_pkg::CNT_W'(1);
                  state_in = (idx_in == face_count_ff) ? rcpi_pkg::ST_FINAL
                                                       : rcpi_pkg::ST_READ;
               end
            end else if (ovf_w) begin
               t_in     = fix_t(neg_w, 1'b1, '0);
               state_in = rcpi_pkg::ST_UPDATE;
            end else begin
               div_start = 1'b1;
               state_in  = rcpi_pkg::ST_DIV;
            end
         end

         rcpi_pkg::ST_DIV: begin
            if (div_done) begin
               t_in     = fix_t(neg_w, 1'b0, div_quo);
               state_in = rcpi_pkg::ST_UPDATE;
            end
         end

         // Clip the interval, then advance to the next face
         rcpi_pkg::ST_UPDATE: begin
            if (vn_ff[63]) begin
               if (t_ff > t_near_ff) begin
                  t_near_in  = t_ff;
                  face_in    = idx_ff[rcpi_pkg::FACE_W-1:0];
                  face_ok_in = 1'b1;
                  ba_in = ra_w; bb_in = rb_w; bc_in = rc_w;
               end
            end else if (t_ff < t_far_ff) begin
               t_far_in = t_ff;
            end
            idx_in   = idx_ff + rcpi_pkg::CNT_W'(1);
            state_in = (idx_in == face_count_ff) ? rcpi_pkg::ST_FINAL : rcpi_pkg::ST_READ;
         end

         rcpi_pkg::ST_FINAL: begin
            step_in = '0;
            sq_in   = '0;
            if (t_near_ff > t_far_ff || t_far_ff[31] || th_w < min_s_w || th_w > tmax_ff) begin
               miss_in  = 1'b1;
               state_in = rcpi_pkg::ST_DONE;
            end else begin
               t_hit_in = th_w;
               if (face_ok_ff) begin
                  state_in = rcpi_pkg::ST_NSQ;
               end else begin
                  nx_in = '0; ny_in = rcpi_pkg::UNIT_ONE; nz_in = '0;
                  state_in = rcpi_pkg::ST_POINT;
               end
            end
         end

         rcpi_pkg::ST_NSQ: begin
            if (step_ff != 3'd0) begin
               sq_in = sq_ff + mp_w;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = rcpi_pkg::ST_SQRT;
            end
         end

         rcpi_pkg::ST_SQRT: begin
            sqrt_start = 1'b1;
            state_in   = rcpi_pkg::ST_SQRT_WAIT;
         end

         rcpi_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in   = (sqrt_root == 32'd0) ? 32'd1 : sqrt_root;
               comp_in  = '0;
               state_in = rcpi_pkg::ST_NDIV;
            end
         end

         rcpi_pkg::ST_NDIV: begin
            div_start = 1'b1;
            state_in  = rcpi_pkg::ST_NDIV_WAIT;
         end

         rcpi_pkg::ST_NDIV_WAIT: begin
            if (div_done) begin
               unique case (comp_ff)
                  2'd0:    nx_in = nval_w;
                  2'd1:    ny_in = nval_w;
                  default: nz_in = nval_w;
               endcase
               comp_in = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  step_in  = '0;
                  state_in = rcpi_pkg::ST_POINT;
               end else begin
                  state_in = rcpi_pkg::ST_NDIV;
               end
            end
         end

         // Hit point: origin plus the floored product of distance and direction
         rcpi_pkg::ST_POINT: begin
            unique case (step_ff)
               3'd1:    px_in = rcpi_pkg::sat32(pt_w + {{32{ox_ff[31]}}, ox_ff});
               3'd2:    py_in = rcpi_pkg::sat32(pt_w + {{32{oy_ff[31]}}, oy_ff});
               3'd3:    pz_in = rcpi_pkg::sat32(pt_w + {{32{oz_ff[31]}}, oz_ff});
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = rcpi_pkg::ST_DONE;
            end
         end

         // Hand the result to the output register once it is free
         rcpi_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_hit_in     = !miss_ff;
               if (miss_ff) begin
                  o_dist_in = '0; o_px_in = '0; o_py_in = '0; o_pz_in = '0;
                  o_nx_in   = '0; o_ny_in = '0; o_nz_in = '0;
                  o_face_in = '0; o_nef_in = 1'b0;
               end else begin
                  o_dist_in = t_hit_ff;
                  o_px_in = px_ff; o_py_in = py_ff; o_pz_in = pz_ff;
                  o_nx_in = nx_ff; o_ny_in = ny_ff; o_nz_in = nz_ff;
                  o_face_in = face_ok_ff ? 5'(face_ff) : 5'd0;
                  o_nef_in  = !face_ok_ff;
               end
               state_in = rcpi_pkg::ST_IDLE;
            end
         end

         default: state_in = rcpi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rcpi_pkg::ST_IDLE;
         face_count_ff <= '0;
         idx_ff        <= '0;
         step_ff       <= '0;
         comp_ff       <= '0;
         face_ok_ff    <= 1'b0;
         miss_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_dist_ff   <= '0;
         thr_ff        <= rcpi_pkg::PAR_THR_RESET;
      end else begin
         state_ff      <= state_in;
         face_count_ff <= face_count_in;
         idx_ff        <= idx_in;
         step_ff       <= step_in;
         comp_ff       <= comp_in;
         face_ok_ff    <= face_ok_in;
         miss_ff       <= miss_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_dist_ff   <= min_dist_in;
         thr_ff        <= thr_in;
      end
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      tmax_ff   <= tmax_in;
      vn_ff     <= vn_in;
      s_ff      <= s_in;
      prod_ff   <= prod_in;
      t_ff      <= t_in;
      t_near_ff <= t_near_in;
      t_far_ff  <= t_far_in;
      t_hit_ff  <= t_hit_in;
      face_ff   <= face_in;
      ba_ff <= ba_in; bb_ff <= bb_in; bc_ff <= bc_in;
      sq_ff  <= sq_in;
      len_ff <= len_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      o_hit_ff  <= o_hit_in;  o_nef_ff <= o_nef_in;
      o_dist_ff <= o_dist_in; o_px_ff  <= o_px_in; o_py_ff <= o_py_in; o_pz_ff <= o_pz_in;
      o_nx_ff   <= o_nx_in;   o_ny_ff  <= o_ny_in; o_nz_ff <= o_nz_in;
      o_face_ff <= o_face_in;
   end

   // Channel outputs
   assign req_ch.ready         = (state_ff == rcpi_pkg::ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = o_hit_ff;
   assign rsp_ch.hit_distance  = o_dist_ff;
   assign rsp_ch.point_x       = o_px_ff;
   assign rsp_ch.point_y       = o_py_ff;
   assign rsp_ch.point_z       = o_pz_ff;
   assign rsp_ch.normal_x      = o_nx_ff;
   assign rsp_ch.normal_y      = o_ny_ff;
   assign rsp_ch.normal_z      = o_nz_ff;
   assign rsp_ch.hit_face      = o_face_ff;
   assign rsp_ch.no_entry_face = o_nef_ff;

endmodule

>>> sv/rcpi_chk.sv
// Port-level checker for the ray / convex polyhedron unit, bound to the top level.
// Depends on the top level's port names only.
module rcpi_chk (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_hit_distance,
   input logic signed [17:0] rsp_normal_x,
   input logic signed [17:0] rsp_normal_y,
   input logic signed [17:0] rsp_normal_z,
   input logic [4:0]         rsp_hit_face,
   input logic               rsp_no_entry_face
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A miss carries no distance, face, no-entry flag or Y normal component
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_distance == 32'sd0 && rsp_hit_face == 5'd0 &&
      !rsp_no_entry_face && rsp_normal_y == 18'sd0)
      else $error("miss response carries data");

   // Without an entering face the normal is straight up
   a_no_entry_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_entry_face |-> rsp_hit && rsp_hit_face == 5'd0 &&
      rsp_normal_x == 18'sd0 && rsp_normal_y == 18'sd65536 && rsp_normal_z == 18'sd0)
      else $error("bad default normal");

   // The X and Z normal components stay within one
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= 18'sd65536 && rsp_normal_x >= -18'sd65536 &&
      rsp_normal_z <= 18'sd65536 && rsp_normal_z >= -18'sd65536)
      else $error("normal component out of range");

endmodule

bind ray_convex_polyhedron_intersect_unit rcpi_chk u_rcpi_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_hit           (rsp_ch.hit),
   .rsp_hit_distance  (rsp_ch.hit_distance),
   .rsp_normal_x      (rsp_ch.normal_x),
   .rsp_normal_y      (rsp_ch.normal_y),
   .rsp_normal_z      (rsp_ch.normal_z),
   .rsp_hit_face      (rsp_ch.hit_face),
   .rsp_no_entry_face (rsp_ch.no_entry_face)
);

>>> tb/tb_ray_convex_polyhedron_intersect_unit.sv
// Self-checking testbench for the ray / convex polyhedron intersection unit.
// Depends on rcpi_pkg, rcpi_if and the unit itself; holds its own predictor class.
`timescale 1ns / 1ps

typedef struct {
   rcpi_pkg::opcode_type opcode;
   logic signed [31:0] coef_a, coef_b, coef_c, coef_d;
   logic signed [31:0] origin_x, origin_y, origin_z;
   logic signed [31:0] dir_x, dir_y, dir_z;
   logic signed [31:0] max_distance;
} ray_request_type;

typedef struct {
   logic               hit;
   logic signed [31:0] hit_distance;
   logic signed [31:0] point_x, point_y, point_z;
   logic signed [17:0] normal_x, normal_y, normal_z;
   logic [4:0]         hit_face;
   logic               no_entry_face;
} ray_hit_type;

// Mirror of the plane table plus the queue of hits still owed by the unit
class polyhedron_tracker;
   logic signed [31:0] plane_a[rcpi_pkg::MAX_FACES];
   logic signed [31:0] plane_b[rcpi_pkg::MAX_FACES];
   logic signed [31:0] plane_c[rcpi_pkg::MAX_FACES];
   logic signed [31:0] plane_d[rcpi_pkg::MAX_FACES];
   int unsigned        face_total;
   logic [30:0]        min_distance;
   logic [31:0]        parallel_threshold;
   ray_hit_type        owed_hits[$];
   int                 errors;

   function void clear_state();
      face_total = 0;
      min_distance = '0;
      parallel_threshold = rcpi_pkg::PAR_THR_RESET;
      errors = 0;
   endfunction

   function logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) return sum[64] ? rcpi_pkg::I64_MIN : rcpi_pkg::I64_MAX;
      return sum[63:0];
   endfunction

   function logic [63:0] magnitude(logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   // Q16.16 quotient, truncated toward zero, clamped to 32 bits
   function longint fixed_divide(logic signed [63:0] num, logic signed [63:0] den);
      logic [63:0] n, d, q, rem, frac, m;
      logic        neg;
      n = magnitude(num);
      d = magnitude(den);
      neg = num[63] != den[63];
      q = n / d;
      rem = n % d;
      frac = 0;
      if (q > 64'h8000) begin
         m = 64'h1_0000_0000;
      end else begin
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= d) begin
               rem = rem - d;
               frac[0] = 1'b1;
            end
         end
         m = (q << 16) | frac;
      end
      if (neg) return (m >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(m);
      return (m > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(m);
   endfunction

   function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function logic signed [17:0] unit_part(logic signed [31:0] c, logic [63:0] len);
      logic [63:0] q;
      q = (magnitude(64'(c)) << 16) / len;
      if (q > 64'd65536) q = 64'd65536;
      return c < 0 ? -18'(q) : 18'(q);
   endfunction

   function logic signed [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return rcpi_pkg::I32_MAX;
      if (x < -64'sd2147483648) return rcpi_pkg::I32_MIN;
      return x[31:0];
   endfunction

   // Clip the ray against every stored plane and build the hit record
   function ray_hit_type trace_ray(ray_request_type rq);
      ray_hit_type        h;
      longint             t_near, t_far, t_hit, t;
      longint             a, b, c;
      logic signed [63:0] vn, s, vd;
      logic [63:0]        len;
      int                 face;
      h = '{default: '0};
      t_near = -64'sd2147483648;
      t_far = 64'sd2147483647;
      face = -1;
      for (int i = 0; i < face_total; i++) begin
         a = plane_a[i];
         b = plane_b[i];
         c = plane_c[i];
         vn = clamp_add(clamp_add(a * rq.dir_x, b * rq.dir_y), c * rq.dir_z);
         s = clamp_add(clamp_add(a * rq.origin_x, b * rq.origin_y), c * rq.origin_z);
         s = clamp_add(s, longint'(plane_d[i]) * 65536);
         vd = (s == rcpi_pkg::I64_MIN) ? rcpi_pkg::I64_MAX : -s;
         if (vn == 0 || magnitude(vn) < 64'(parallel_threshold)) begin
            if (vd < 0) return h;
         end else begin
            t = fixed_divide(vd, vn);
            if (vn < 0) begin
               if (t > t_near) begin
                  t_near = t;
                  face = i;
               end
            end else if (t < t_far) begin
               t_far = t;
            end
         end
      end
      if (t_near > t_far || t_far < 0) return h;
      t_hit = t_near;
      if (t_hit < longint'(min_distance)) begin
         t_hit = t_far;
         if (t_hit < longint'(min_distance)) return h;
      end
      if (t_hit > longint'(rq.max_distance)) return h;
      h.hit = 1'b1;
      h.hit_distance = t_hit[31:0];
      h.point_x = clamp32(longint'(rq.origin_x) + ((t_hit * rq.dir_x) >>> 16));
      h.point_y = clamp32(longint'(rq.origin_y) + ((t_hit * rq.dir_y) >>> 16));
      h.point_z = clamp32(longint'(rq.origin_z) + ((t_hit * rq.dir_z) >>> 16));
      if (face >= 0) begin
         len = root_floor(magnitude(64'(plane_a[face])) * magnitude(64'(plane_a[face])) +
                          magnitude(64'(plane_b[face])) * magnitude(64'(plane_b[face])) +
                          magnitude(64'(plane_c[face])) * magnitude(64'(plane_c[face])));
         if (len == 0) len = 1;
         h.normal_x = unit_part(plane_a[face], len);
         h.normal_y = unit_part(plane_b[face], len);
         h.normal_z = unit_part(plane_c[face], len);
         h.hit_face = face[4:0];
      end else begin
         h.normal_y = rcpi_pkg::UNIT_ONE;
         h.no_entry_face = 1'b1;
      end
      return h;
   endfunction

   function void note_request(ray_request_type rq);
      case (rq.opcode)
         rcpi_pkg::OP_CLEAR: face_total = 0;
         rcpi_pkg::OP_APPEND: begin
            if (face_total < rcpi_pkg::MAX_FACES) begin
               plane_a[face_total] = rq.coef_a;
               plane_b[face_total] = rq.coef_b;
               plane_c[face_total] = rq.coef_c;
               plane_d[face_total] = rq.coef_d;
               face_total++;
            end
         end
         rcpi_pkg::OP_TRACE: owed_hits.push_back(trace_ray(rq));
         default: ;
      endcase
   endfunction

   function void check_response(ray_hit_type got);
      ray_hit_type want;
      if (owed_hits.size() == 0) begin
         $error("unexpected response transfer");
         errors++;
         return;
      end
      want = owed_hits.pop_front();
      if (got.hit !== want.hit) begin
         $error("hit: expected %0d, actual %0d", want.hit, got.hit); errors++;
      end
      if (got.hit_distance !== want.hit_distance) begin
         $error("hit_distance: expected %0d, actual %0d", want.hit_distance, got.hit_distance);
         errors++;
      end
      if (got.point_x !== want.point_x) begin
         $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x); errors++;
      end
      if (got.point_y !== want.point_y) begin
         $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y); errors++;
      end
      if (got.point_z !== want.point_z) begin
         $error("point_z: expected %0d, actual %0d", want.point_z, got.point_z); errors++;
      end
      if (got.normal_x !== want.normal_x) begin
         $error("normal_x: expected %0d, actual %0d", want.normal_x, got.normal_x); errors++;
      end
      if (got.normal_y !== want.normal_y) begin
         $error("normal_y: expected %0d, actual %0d", want.normal_y, got.normal_y); errors++;
      end
      if (got.normal_z !== want.normal_z) begin
         $error("normal_z: expected %0d, actual %0d", want.normal_z, got.normal_z); errors++;
      end
      if (got.hit_face !== want.hit_face) begin
         $error("hit_face: expected %0d, actual %0d", want.hit_face, got.hit_face); errors++;
      end
      if (got.no_entry_face !== want.no_entry_face) begin
         $error("no_entry_face: expected %0d, actual %0d", want.no_entry_face,
                got.no_entry_face);
         errors++;
      end
   endfunction
endclass

module tb_ray_convex_polyhedron_intersect_unit;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int UNIT = 65536;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          cycle_count;
   int          burst_left;
   int          requests_sent;
   polyhedron_tracker tracker;

   rcpi_req_if req_ch();
   rcpi_rsp_if rsp_ch();

   ray_convex_polyhedron_intersect_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ray_convex_polyhedron_intersect_unit] ERROR");
         $finish;
      end
   end

   // Receiver: stall pattern changes mode now and then, with two long hold-offs
   initial begin : receiver
      int mode;
      int mode_left;
      int held;
      mode = 0;
      mode_left = 0;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         held++;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 400);
         end
         mode_left--;
         if ((held >= 20000 && held < 24000) || (held >= 150000 && held < 152000)) begin
            rsp_ch.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = $urandom_range(0, 1);
               default: rsp_ch.ready = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Check each response transfer against the oldest owed hit
   always @(posedge clock) begin
      ray_hit_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.hit = rsp_ch.hit;
         got.hit_distance = rsp_ch.hit_distance;
         got.point_x = rsp_ch.point_x;
         got.point_y = rsp_ch.point_y;
         got.point_z = rsp_ch.point_z;
         got.normal_x = rsp_ch.normal_x;
         got.normal_y = rsp_ch.normal_y;
         got.normal_z = rsp_ch.normal_z;
         got.hit_face = rsp_ch.hit_face;
         got.no_entry_face = rsp_ch.no_entry_face;
         tracker.check_response(got);
      end
   end

   // Offer one request; bursts of random length separated by random gaps
   task automatic send_request(ray_request_type rq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.opcode = rq.opcode;
      req_ch.coef_a = rq.coef_a;
      req_ch.coef_b = rq.coef_b;
      req_ch.coef_c = rq.coef_c;
      req_ch.coef_d = rq.coef_d;
      req_ch.origin_x = rq.origin_x;
      req_ch.origin_y = rq.origin_y;
      req_ch.origin_z = rq.origin_z;
      req_ch.dir_x = rq.dir_x;
      req_ch.dir_y = rq.dir_y;
      req_ch.dir_z = rq.dir_z;
      req_ch.max_distance = rq.max_distance;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(rq);
      if (rq.opcode != rcpi_pkg::OP_NOP) requests_sent++;
   endtask

   // Drop valid and wait until every owed hit is back
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left = 0;
      while (tracker.owed_hits.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == rcpi_pkg::REG_MIN_DIST) tracker.min_distance = value[30:0];
      else tracker.parallel_threshold = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   function automatic ray_request_type filled_request(rcpi_pkg::opcode_type op,
                                                      logic [31:0] v);
      return '{op, v, v, v, v, v, v, v, v, v, v, v};
   endfunction

   function automatic ray_request_type plane_request(int a, int b, int c, int d);
      ray_request_type rq;
      rq = filled_request(rcpi_pkg::OP_APPEND, '0);
      rq.coef_a = $urandom;
      rq.origin_x = $urandom;
      rq.coef_a = a;
      rq.coef_b = b;
      rq.coef_c = c;
      rq.coef_d = d;
      return rq;
   endfunction

   function automatic ray_request_type ray_request(int ox, int oy, int oz, int dx, int dy,
                                                   int dz, int tmax);
      ray_request_type rq;
      rq = filled_request(rcpi_pkg::OP_TRACE, '0);
      rq.coef_a = $urandom;
      rq.coef_d = $urandom;
      rq.origin_x = ox;
      rq.origin_y = oy;
      rq.origin_z = oz;
      rq.dir_x = dx;
      rq.dir_y = dy;
      rq.dir_z = dz;
      rq.max_distance = tmax;
      return rq;
   endfunction

   function automatic ray_request_type noise_request();
      ray_request_type rq;
      rq.opcode = rcpi_pkg::opcode_type'($urandom_range(0, 3));
      rq.coef_a = $urandom;
      rq.coef_b = $urandom;
      rq.coef_c = $urandom;
      rq.coef_d = $urandom;
      rq.origin_x = $urandom;
      rq.origin_y = $urandom;
      rq.origin_z = $urandom;
      rq.dir_x = $urandom;
      rq.dir_y = $urandom;
      rq.dir_z = $urandom;
      rq.max_distance = $urandom;
      return rq;
   endfunction

   function automatic int signed_range(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // Clear, then a box with scaled normals plus random planes around the origin
   task automatic build_polyhedron();
      int extra;
      int h;
      int k;
      int d;
      send_request(filled_request(rcpi_pkg::OP_CLEAR, $urandom));
      case ($urandom_range(0, 19))
         0: extra = $urandom_range(26, 30);
         1: extra = 0;
         default: extra = $urandom_range(0, 6);
      endcase
      for (int axis = 0; axis < 6; axis++) begin
         h = $urandom_range(UNIT / 4, 12 * UNIT);
         k = $urandom_range(UNIT / 8, 4 * UNIT);
         if (axis % 2) k = -k;
         d = int'(-((longint'(k < 0 ? -k : k) * h) >>> 16));
         case (axis / 2)
            0: send_request(plane_request(k, 0, 0, d));
            1: send_request(plane_request(0, k, 0, d));
            default: send_request(plane_request(0, 0, k, d));
         endcase
      end
      for (int i = 0; i < extra; i++) begin
         send_request(plane_request(signed_range(2 * UNIT), signed_range(2 * UNIT),
                                    signed_range(2 * UNIT), -$urandom_range(UNIT, 10 * UNIT)));
      end
   endtask

   // Rays mostly aimed at the center from outside, some axis-aligned or from inside
   task automatic shoot_rays();
      int ox, oy, oz, dx, dy, dz, tmax;
      repeat ($urandom_range(2, 8)) begin
         if ($urandom_range(0, 4) == 0) begin
            ox = signed_range(UNIT);
            oy = signed_range(UNIT);
            oz = signed_range(UNIT);
         end else begin
            ox = signed_range(30 * UNIT);
            oy = signed_range(30 * UNIT);
            oz = signed_range(30 * UNIT);
         end
         case ($urandom_range(0, 5))
            0: begin
               dx = signed_range(UNIT);
               dy = 0;
               dz = 0;
            end
            1: begin
               dx = signed_range(4 * UNIT);
               dy = signed_range(4 * UNIT);
               dz = signed_range(4 * UNIT);
            end
            default: begin
               dx = (-ox >>> 3) + signed_range(UNIT / 2);
               dy = (-oy >>> 3) + signed_range(UNIT / 2);
               dz = (-oz >>> 3) + signed_range(UNIT / 2);
            end
         endcase
         tmax = ($urandom_range(0, 2) == 0) ? signed_range(20 * UNIT) : rcpi_pkg::I32_MAX;
         send_request(ray_request(ox, oy, oz, dx, dy, dz, tmax));
      end
   endtask

   initial begin : stimulus
      logic [30:0] min_set[6];
      logic [31:0] thr_set[6];
      tracker = new();
      tracker.clear_state();
      cycle_count = 0;
      burst_left = 0;
      requests_sent = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = rcpi_pkg::OP_CLEAR;
      {req_ch.coef_a, req_ch.coef_b, req_ch.coef_c, req_ch.coef_d} = '0;
      {req_ch.origin_x, req_ch.origin_y, req_ch.origin_z} = '0;
      {req_ch.dir_x, req_ch.dir_y, req_ch.dir_z, req_ch.max_distance} = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, extremes, unused opcode, parallel planes
      send_request(ray_request(0, 0, 0, UNIT, 0, 0, rcpi_pkg::I32_MAX));
      send_request(filled_request(rcpi_pkg::OP_TRACE, 32'h8000_0000));
      send_request(filled_request(rcpi_pkg::OP_TRACE, 32'h7FFF_FFFF));
      send_request(filled_request(rcpi_pkg::OP_NOP, $urandom));
      send_request(plane_request(UNIT, 0, 0, -UNIT));
      send_request(ray_request(0, 0, 0, 0, UNIT, 0, rcpi_pkg::I32_MAX));
      send_request(ray_request(-5 * UNIT, 0, 0, UNIT, 0, 0, rcpi_pkg::I32_MAX));
      send_request(ray_request(-5 * UNIT, 0, 0, UNIT, 0, 0, UNIT));
      send_request(plane_request(0, UNIT, 0, UNIT));
      send_request(ray_request(0, 0, 0, UNIT, 0, 0, rcpi_pkg::I32_MAX));
      send_request(filled_request(rcpi_pkg::OP_CLEAR, '0));
      send_request(filled_request(rcpi_pkg::OP_APPEND, 32'h8000_0000));
      send_request(filled_request(rcpi_pkg::OP_APPEND, 32'h7FFF_FFFF));
      send_request(ray_request(UNIT, -UNIT, UNIT, -UNIT, UNIT, -UNIT, rcpi_pkg::I32_MAX));
      send_request(filled_request(rcpi_pkg::OP_TRACE, 32'h8000_0000));
      send_request(filled_request(rcpi_pkg::OP_CLEAR, 32'hFFFF_FFFF));

      // Register settings per phase, extremes included
      min_set = '{31'd0, 31'd0, 31'h7FFF_FFFF, 31'd65536, 31'($urandom_range(0, 4 * UNIT)),
                  31'd0};
      thr_set = '{32'd0, 32'd4295, 32'd4295, 32'hFFFF_FFFF, $urandom_range(0, 1 << 20),
                  rcpi_pkg::PAR_THR_RESET};
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         csr_write(rcpi_pkg::REG_MIN_DIST, {1'b0, min_set[phase]});
         csr_write(rcpi_pkg::REG_PAR_THR, thr_set[phase]);
         while (requests_sent < 40 + (phase + 1) * 215) begin
            if ($urandom_range(0, 3) != 0) begin
               build_polyhedron();
               shoot_rays();
            end else begin
               repeat ($urandom_range(1, 4)) send_request(noise_request());
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed_hits.size() == 0) begin
         $display("[ray_convex_polyhedron_intersect_unit] OK");
      end else begin
         $display("[ray_convex_polyhedron_intersect_unit] ERROR");
      end
      $finish;
   end
endmodule
